// ===== sv/amdo_pkg.sv =====
// amdo_pkg: shared types, constants and address decode functions for the
// address map decoder with sprite-attribute dma; no dependencies
package amdo_pkg;

    localparam int RAM_BYTES  = 32768;
    localparam int RAM_AW     = $clog2(RAM_BYTES);
    localparam int DMA_LENGTH = 160;
    localparam int CNT_W      = 8;

    localparam logic [15:0] BOOT_END     = 16'h00FF;
    localparam logic [15:0] RAM_BASE     = 16'h8000;
    localparam logic [15:0] CRAM_LO      = 16'hA000;
    localparam logic [15:0] CRAM_HI      = 16'hBFFF;
    localparam logic [15:0] ECHO_LO      = 16'hE000;
    localparam logic [15:0] ECHO_HI      = 16'hFDFF;
    localparam logic [15:0] ECHO_SHIFT   = 16'h2000;
    localparam logic [15:0] OAM_BASE     = 16'hFE00;
    localparam logic [15:0] OAM_END      = 16'hFE9F;
    localparam logic [15:0] UNUSED_LO    = 16'hFEA0;
    localparam logic [15:0] UNUSED_HI    = 16'hFEFF;
    localparam logic [15:0] DMA_REG      = 16'hFF46;
    localparam logic [15:0] BOOT_OFF_REG = 16'hFF50;
    localparam logic [7:0]  UNUSED_BYTE  = 8'hFF;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_RD_UNMAPPED = 2'd1;
    localparam logic [1:0] ST_WR_UNMAPPED = 2'd2;

    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_BOOT = 2'd1;
    localparam logic [1:0] TGT_ROM  = 2'd2;
    localparam logic [1:0] TGT_CRAM = 2'd3;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CART = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT = 1'b1;

    // where the byte of a read comes from
    typedef enum logic [1:0] {
        RS_ZERO = 2'd0,
        RS_EXT  = 2'd1,
        RS_FF   = 2'd2,
        RS_RAM  = 2'd3
    } t_rsrc;

    typedef struct packed {
        t_rsrc             rsrc;
        logic [1:0]        status;
        logic [1:0]        target;
        logic [RAM_AW-1:0] idx;
    } t_rd_dec;

    typedef struct packed {
        logic              ram_we;
        logic [1:0]        status;
        logic [1:0]        target;
        logic [RAM_AW-1:0] idx;
    } t_wr_dec;

    function automatic logic [RAM_AW-1:0] ram_index(input logic [15:0] a);
        logic [15:0] off;
        off = a - RAM_BASE;
        return off[RAM_AW-1:0];
    endfunction

    function automatic t_rd_dec decode_read(input logic [15:0] a, input logic overlay,
                                            input logic cart);
        t_rd_dec d;
        d.rsrc   = RS_RAM;
        d.status = ST_OK;
        d.target = TGT_NONE;
        d.idx    = ram_index(a);
        if (a <= BOOT_END && overlay) begin
            d.rsrc   = RS_EXT;
            d.target = TGT_BOOT;
        end else if (a < RAM_BASE || a inside {[CRAM_LO:CRAM_HI]}) begin
            if (cart) begin
                d.rsrc   = RS_EXT;
                d.target = (a < RAM_BASE) ? TGT_ROM : TGT_CRAM;
            end else begin
                d.rsrc   = RS_ZERO;
                d.status = ST_RD_UNMAPPED;
            end
        end else if (a inside {[ECHO_LO:ECHO_HI]}) begin
            d.idx = ram_index(a - ECHO_SHIFT);
        end else if (a inside {[UNUSED_LO:UNUSED_HI]}) begin
            d.rsrc = RS_FF;
        end
        return d;
    endfunction

    function automatic t_wr_dec decode_write(input logic [15:0] a, input logic cart);
        t_wr_dec d;
        d.ram_we = 1'b1;
        d.status = ST_OK;
        d.target = TGT_NONE;
        d.idx    = ram_index(a);
        if (a < RAM_BASE || a inside {[CRAM_LO:CRAM_HI]}) begin
            d.ram_we = 1'b0;
            if (cart) begin
                d.target = (a < RAM_BASE) ? TGT_ROM : TGT_CRAM;
            end else begin
                d.status = ST_WR_UNMAPPED;
            end
        end else if (a inside {[ECHO_LO:ECHO_HI]}) begin
            d.idx = ram_index(a - ECHO_SHIFT);
        end else if (a inside {[UNUSED_LO:UNUSED_HI]}) begin
            d.ram_we = 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== sv/address_map_decoder_with_oam_dma_core.sv =====
// address_map_decoder_with_oam_dma_core: byte access decoder over the 16-bit map,
// internal ram, boot overlay control and sprite-attribute dma engine
// depends on amdo_pkg
//
// Every accepted request uses the single internal ram in an accept and a finish
// cycle: the accept cycle decodes the address and reads the ram, the finish
// cycle picks the result byte and does the ram write (a store, or the dma copy
// into 0xFE00 upward). The result is strobed on o_done for exactly one cycle
// right after that and cannot be held off; busy is already low again in that
// cycle, so a new request can be started while the result is shown. ext_data
// must come with the request and holds the byte the external port returns at
// the target and address that this request reports. After reset the ram is
// cleared one byte a cycle, with busy high until all 32768 bytes are done;
// configuration writes are taken in every state, during that pass as well.
module address_map_decoder_with_oam_dma_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_operation,
    input  logic [15:0]                    i_address,
    input  logic [7:0]                     i_write_data,
    input  logic [7:0]                     i_ext_data,
    input  logic                           i_cfg_we,
    input  logic [amdo_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [0:0]                     i_cfg_data,
    output logic                           o_done,
    output logic [7:0]                     o_read_data,
    output logic [1:0]                     o_status,
    output logic [1:0]                     o_ext_target,
    output logic [15:0]                    o_ext_address,
    output logic                           o_ext_write,
    output logic [7:0]                     o_ext_write_data,
    output logic                           o_dma_busy
);

    localparam int AW = amdo_pkg::RAM_AW;
    localparam int CW = amdo_pkg::CNT_W;
    localparam logic [CW:0] DMA_LEN = (CW+1)'(amdo_pkg::DMA_LENGTH);
    localparam logic [AW-1:0] CLR_LAST = AW'(amdo_pkg::RAM_BYTES - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_FIN
    } t_state;

    t_state r_state;

    logic [7:0] mem [amdo_pkg::RAM_BYTES];
    logic [7:0] r_ram_q;

    logic           r_cart_present;
    logic           r_boot_present;
    logic           r_boot_overlay_on;
    logic           r_dma_running;
    logic [15:0]    r_dma_source_base;
    logic [CW-1:0]  r_dma_count;
    logic [AW-1:0]  r_clr_idx;

    // request latched at accept
    amdo_pkg::t_rsrc r_rsrc;
    logic [1:0]      r_status;
    logic [1:0]      r_target;
    logic [15:0]     r_ext_addr;
    logic            r_ext_wr;
    logic [7:0]      r_ext_wdata;
    logic [7:0]      r_wdata;
    logic [7:0]      r_ext_data;
    logic            r_ram_we;
    logic [AW-1:0]   r_widx;
    logic            r_wsel_read;
    logic            r_dma_step;
    logic            r_dma_start;
    logic            r_boot_off;

    logic           r_done;
    logic [7:0]     r_read_data;
    logic [1:0]     r_o_status;
    logic [1:0]     r_o_target;
    logic [15:0]    r_o_ext_addr;
    logic           r_o_ext_wr;
    logic [7:0]     r_o_ext_wdata;
    logic           r_o_dma_busy;

    amdo_pkg::t_op    op;
    amdo_pkg::t_rd_dec rd_dec;
    amdo_pkg::t_wr_dec wr_dec;
    logic            accept;
    logic [15:0]     dma_src;
    logic [15:0]     dma_dst;
    logic [15:0]     rd_addr;
    logic [7:0]      rd_data;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [CW:0]     cnt_next;
    logic            n_dma_running;
    logic [CW-1:0]   n_dma_count;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign op     = amdo_pkg::t_op'(i_operation);

    assign dma_src = r_dma_source_base + {{(16-CW){1'b0}}, r_dma_count};
    assign dma_dst = amdo_pkg::OAM_BASE + {{(16-CW){1'b0}}, r_dma_count};
    assign rd_addr = (op == amdo_pkg::OP_TICK) ? dma_src : i_address;

    always_comb begin
        rd_dec = amdo_pkg::decode_read(rd_addr, r_boot_overlay_on & r_boot_present,
                                       r_cart_present);
        wr_dec = amdo_pkg::decode_write(i_address, r_cart_present);
    end

    always_comb begin
        case (r_rsrc)
            amdo_pkg::RS_ZERO: rd_data = 8'h00;
            amdo_pkg::RS_EXT:  rd_data = r_ext_data;
            amdo_pkg::RS_FF:   rd_data = amdo_pkg::UNUSED_BYTE;
            amdo_pkg::RS_RAM:  rd_data = r_ram_q;
            default:           rd_data = 8'h00;
        endcase
    end

    // a request writes the ram only in its finish cycle and uses the byte read in
    // its accept cycle, so a following request always reads the updated byte
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_widx;
        ram_wdata = r_wsel_read ? rd_data : r_wdata;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_idx;
            ram_wdata = 8'h00;
        end else if (r_state == S_FIN) begin
            ram_we = r_ram_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            mem[ram_waddr] <= ram_wdata;
        end
        r_ram_q <= mem[rd_dec.idx];
    end

    always_comb begin
        cnt_next      = {1'b0, r_dma_count} + (CW+1)'(1);
        n_dma_running = r_dma_running;
        n_dma_count   = r_dma_count;
        if (r_state == S_FIN) begin
            if (r_dma_step) begin
                n_dma_count = cnt_next[CW-1:0];
                if (cnt_next >= DMA_LEN) begin
                    n_dma_running = 1'b0;
                end
            end
            if (r_dma_start) begin
                n_dma_running = 1'b1;
                n_dma_count   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_CLEAR;
            r_clr_idx         <= '0;
            r_cart_present    <= 1'b1;
            r_boot_present    <= 1'b1;
            r_boot_overlay_on <= 1'b1;
            r_dma_running     <= 1'b0;
            r_dma_source_base <= '0;
            r_dma_count       <= '0;
            r_done            <= 1'b0;
            r_read_data       <= '0;
            r_o_status        <= amdo_pkg::ST_OK;
            r_o_target        <= amdo_pkg::TGT_NONE;
            r_o_ext_addr      <= '0;
            r_o_ext_wr        <= 1'b0;
            r_o_ext_wdata     <= '0;
            r_o_dma_busy      <= 1'b0;
            r_ram_we          <= 1'b0;
            r_dma_step        <= 1'b0;
            r_dma_start       <= 1'b0;
            r_boot_off        <= 1'b0;
        end else begin
            r_done        <= 1'b0;
            r_dma_running <= n_dma_running;
            r_dma_count   <= n_dma_count;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    amdo_pkg::CFG_CART: r_cart_present <= i_cfg_data[0];
                    amdo_pkg::CFG_BOOT: r_boot_present <= i_cfg_data[0];
                    default: ;
                endcase
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + AW'(1);
                    if (r_clr_idx == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state     <= S_FIN;
                        r_wdata     <= i_write_data;
                        r_ext_data  <= i_ext_data;
                        r_rsrc      <= amdo_pkg::RS_ZERO;
                        r_status    <= amdo_pkg::ST_OK;
                        r_target    <= amdo_pkg::TGT_NONE;
                        r_ext_addr  <= '0;
                        r_ext_wr    <= 1'b0;
                        r_ext_wdata <= '0;
                        r_ram_we    <= 1'b0;
                        r_widx      <= wr_dec.idx;
                        r_wsel_read <= 1'b0;
                        r_dma_step  <= 1'b0;
                        r_dma_start <= 1'b0;
                        r_boot_off  <= 1'b0;
                        case (op)
                            amdo_pkg::OP_READ: begin
                                r_rsrc   <= rd_dec.rsrc;
                                r_status <= rd_dec.status;
                                r_target <= rd_dec.target;
                                if (rd_dec.target != amdo_pkg::TGT_NONE) begin
                                    r_ext_addr <= i_address;
                                end
                            end
                            amdo_pkg::OP_WRITE: begin
                                r_status <= wr_dec.status;
                                r_target <= wr_dec.target;
                                r_ram_we <= wr_dec.ram_we;
                                if (wr_dec.target != amdo_pkg::TGT_NONE) begin
                                    r_ext_addr  <= i_address;
                                    r_ext_wr    <= 1'b1;
                                    r_ext_wdata <= i_write_data;
                                end
                                r_dma_start <= (i_address == amdo_pkg::DMA_REG) &&
                                               !r_dma_running;
                                r_boot_off  <= (i_address == amdo_pkg::BOOT_OFF_REG) &&
                                               (i_write_data != 8'h00);
                            end
                            amdo_pkg::OP_TICK: begin
                                if (r_dma_running) begin
                                    r_rsrc      <= rd_dec.rsrc;
                                    r_status    <= rd_dec.status;
                                    r_target    <= rd_dec.target;
                                    if (rd_dec.target != amdo_pkg::TGT_NONE) begin
                                        r_ext_addr <= dma_src;
                                    end
                                    // bytes aimed past the end of oam are dropped
                                    r_ram_we    <= (dma_dst <= amdo_pkg::OAM_END);
                                    r_widx      <= amdo_pkg::ram_index(dma_dst);
                                    r_wsel_read <= 1'b1;
                                    r_dma_step  <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_FIN: begin
                    r_state       <= S_IDLE;
                    r_done        <= 1'b1;
                    r_read_data   <= rd_data;
                    r_o_status    <= r_status;
                    r_o_target    <= r_target;
                    r_o_ext_addr  <= r_ext_addr;
                    r_o_ext_wr    <= r_ext_wr;
                    r_o_ext_wdata <= r_ext_wdata;
                    r_o_dma_busy  <= n_dma_running;
                    if (r_dma_start) begin
                        r_dma_source_base <= {r_wdata, 8'h00};
                    end
                    if (r_boot_off) begin
                        r_boot_overlay_on <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done           = r_done;
    assign o_read_data      = r_read_data;
    assign o_status         = r_o_status;
    assign o_ext_target     = r_o_target;
    assign o_ext_address    = r_o_ext_addr;
    assign o_ext_write      = r_o_ext_wr;
    assign o_ext_write_data = r_o_ext_wdata;
    assign o_dma_busy       = r_o_dma_busy;

    // every request strobes its result on o_done after its finish state
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_done)
        else $error("result strobe missing after request");

    a_done_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_FIN))
        else $error("result strobe without a finished request");

    a_unmapped_no_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != amdo_pkg::ST_OK) |->
            (o_ext_target == amdo_pkg::TGT_NONE && o_read_data == 8'h00))
        else $error("unmapped access drove the external port");

    a_ext_write_cart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_ext_write) |->
            (o_ext_target == amdo_pkg::TGT_ROM || o_ext_target == amdo_pkg::TGT_CRAM))
        else $error("external write to a read-only target");

    a_dma_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dma_running |-> ({1'b0, r_dma_count} < DMA_LEN))
        else $error("dma count beyond copy length");

endmodule
